// ===== rtl/tvp_pkg.sv =====
// Shared types and constants for the tag/value field parser.
package tvp_pkg;

  localparam int unsigned MaxTags = 7;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] CfgSeparator = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgTagFirst  = 4'd1;

  localparam logic [7:0] SepReset  = 8'd59;
  localparam logic [7:0] CharEqual = 8'h3D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [15:0] MaxPosition = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BADTAG  = 3'd2,
    ST_UNTERM  = 3'd3,
    ST_TOOLONG = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] field_tag;
    logic [2:0]  slot_index;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    status_e     status;
    logic        end_of_message;
  } result_t;

  function automatic logic [15:0] tag_reset(input int unsigned idx);
    logic [15:0] v;
    case (idx)
      0:       v = 16'd8;
      1:       v = 16'd9;
      2:       v = 16'd35;
      3:       v = 16'd48;
      4:       v = 16'd22;
      5:       v = 16'd11;
      default: v = 16'd41;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tvp_slot_match.sv =====
// Accepted-tag comparison: lowest enabled slot whose tag equals the field tag.
module tvp_slot_match import tvp_pkg::*; #(
  parameter int unsigned NUM_TAGS = 7
) (
  input  logic [NUM_TAGS-1:0][15:0] accepted_tag_i,
  input  logic [15:0]               tag_i,
  output logic [2:0]                slot_o
);

  always_comb begin
    slot_o = 3'd0;
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if (accepted_tag_i[i] != 16'd0 && accepted_tag_i[i] == tag_i) begin
        slot_o = 3'(i + 1);
      end
    end
  end

endmodule

// ===== rtl/tvp_out_buf.sv =====
// Result register with a skid stage so the parser keeps taking bytes under backpressure.
module tvp_out_buf import tvp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    can_push_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = push_data_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = push_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign can_push_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/tag_value_field_parser.sv =====
// Top level of the tag/value field parser.
// Parses "tag=value<sep>" fields one message byte per cycle and emits one transaction per
// completed field (tag, matching slot, value offset and length) or per error, after which
// the rest of the message is dropped up to its last byte. Each byte is decoded
// combinationally from the parser state into a result register backed by a skid stage, so
// a byte is taken every cycle; in_ready_o drops only while both result stages hold
// undelivered results. Configuration writes are always accepted.
module tag_value_field_parser import tvp_pkg::*; #(
  parameter int unsigned NUM_TAGS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        field_tag_o,
  output logic [2:0]         slot_index_o,
  output logic [15:0]        value_offset_o,
  output logic [15:0]        value_length_o,
  output logic [2:0]         status_o,
  output logic               end_of_message_o
);

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_e;

  logic [7:0]               sep_q;
  logic [NUM_TAGS-1:0][15:0] acc_tag_q;

  phase_e      phase_q, phase_d;
  logic [15:0] tag_q, tag_d;
  logic        seen_q, seen_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] vstart_q, vstart_d;

  logic        in_acc;
  logic        push;
  result_t     res;
  result_t     out_res;
  logic [2:0]  slot;
  logic [19:0] tag_next;
  logic [15:0] val_len;
  logic        err;
  status_e     err_st;
  logic        clear;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepReset;
      for (int i = 0; i < NUM_TAGS; i++) begin
        acc_tag_q[i] <= tag_reset(i);
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSeparator) begin
        sep_q <= cfg_data_i[7:0];
      end
      for (int i = 0; i < NUM_TAGS; i++) begin
        if (cfg_index_i == CfgTagFirst + CfgIdxW'(i)) begin
          acc_tag_q[i] <= cfg_data_i;
        end
      end
    end
  end

  tvp_slot_match #(
    .NUM_TAGS(NUM_TAGS)
  ) u_slot_match (
    .accepted_tag_i(acc_tag_q),
    .tag_i         (tag_q),
    .slot_o        (slot)
  );

  assign in_acc   = in_valid_i && in_ready_o;
  assign tag_next = {1'b0, tag_q, 3'b000} + {3'b000, tag_q, 1'b0}
                  + {16'd0, 4'(data_byte_i - CharZero)};
  assign val_len  = pos_q - vstart_q;

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    seen_d   = seen_q;
    pos_d    = pos_q;
    vstart_d = vstart_q;
    push     = 1'b0;
    err      = 1'b0;
    err_st   = ST_OK;
    clear    = 1'b0;
    res      = '{field_tag: tag_q, slot_index: slot, value_offset: vstart_q,
                 value_length: val_len, status: ST_OK, end_of_message: last_byte_i};
    if (in_acc) begin
      unique case (phase_q)
        PH_TAG: begin
          if (pos_q == MaxPosition) begin
            err    = 1'b1;
            err_st = ST_TOOLONG;
          end else if (data_byte_i == CharEqual) begin
            if (!seen_q) begin
              err    = 1'b1;
              err_st = ST_BADTAG;
            end else if (last_byte_i) begin
              err    = 1'b1;
              err_st = ST_UNTERM;
            end else begin
              phase_d  = PH_VALUE;
              vstart_d = pos_q + 16'd1;
              pos_d    = pos_q + 16'd1;
            end
          end else if (data_byte_i >= CharZero && data_byte_i <= CharNine) begin
            if (tag_next[19:16] != 4'd0) begin
              err    = 1'b1;
              err_st = ST_BADTAG;
            end else if (last_byte_i) begin
              err    = 1'b1;
              err_st = ST_UNTERM;
            end else begin
              tag_d  = tag_next[15:0];
              seen_d = 1'b1;
              pos_d  = pos_q + 16'd1;
            end
          end else begin
            err    = 1'b1;
            err_st = ST_BADTAG;
          end
        end
        PH_VALUE: begin
          if (pos_q == MaxPosition) begin
            err    = 1'b1;
            err_st = ST_TOOLONG;
          end else if (data_byte_i == sep_q) begin
            if (val_len == 16'd0) begin
              err    = 1'b1;
              err_st = ST_EMPTY;
            end else begin
              push = 1'b1;
              if (last_byte_i) begin
                clear = 1'b1;
              end else begin
                phase_d = PH_TAG;
                tag_d   = '0;
                seen_d  = 1'b0;
                pos_d   = pos_q + 16'd1;
              end
            end
          end else if (last_byte_i) begin
            err    = 1'b1;
            err_st = ST_UNTERM;
          end else begin
            pos_d = pos_q + 16'd1;
          end
        end
        PH_SKIP: begin
          clear = last_byte_i;
        end
        default: begin
          clear = 1'b1;
        end
      endcase
      if (err) begin
        push = 1'b1;
        res  = '{field_tag: 16'd0, slot_index: 3'd0, value_offset: pos_q,
                 value_length: 16'd0, status: err_st, end_of_message: last_byte_i};
        if (last_byte_i) begin
          clear = 1'b1;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      if (clear) begin
        phase_d  = PH_TAG;
        tag_d    = '0;
        seen_d   = 1'b0;
        pos_d    = '0;
        vstart_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      tag_q    <= '0;
      seen_q   <= 1'b0;
      pos_q    <= '0;
      vstart_q <= '0;
    end else begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      seen_q   <= seen_d;
      pos_q    <= pos_d;
      vstart_q <= vstart_d;
    end
  end

  tvp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(res),
    .can_push_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res)
  );

  assign field_tag_o      = out_res.field_tag;
  assign slot_index_o     = out_res.slot_index;
  assign value_offset_o   = out_res.value_offset;
  assign value_length_o   = out_res.value_length;
  assign status_o         = out_res.status;
  assign end_of_message_o = out_res.end_of_message;

  // checks
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> phase_q == PH_TAG && pos_q == 16'd0 && !seen_q)
    else $error("parser not restarted after last byte");

  a_value_has_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VALUE |-> seen_q && vstart_q <= pos_q && vstart_q != 16'd0)
    else $error("value phase without a tag");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.status != ST_OK |-> res.field_tag == 16'd0 && res.value_length == 16'd0)
    else $error("error result carries field data");

endmodule

// ===== tb/tvp_tb_pkg.sv =====
// Scoreboard and parser prediction for the tag/value field parser testbench.
`timescale 1ns / 1ps
package tvp_tb_pkg;
  import tvp_pkg::*;

  typedef enum logic [1:0] {
    PARSE_TAG,
    PARSE_VALUE,
    PARSE_SKIP
  } parse_state_e;

  class field_scoreboard;
    logic [7:0]   sep_char;
    logic [15:0]  accepted_tags [MaxTags];
    parse_state_e state;
    logic [15:0]  tag_acc;
    bit           have_digit;
    logic [15:0]  position;
    logic [15:0]  value_start;
    result_t      expected_fields [$];
    int unsigned  errors;
    int unsigned  bytes_taken;
    int unsigned  results_checked;
    int unsigned  fields_ok;
    int unsigned  errors_flagged;
    int unsigned  reg_writes;

    function new();
      int unsigned reset_tags [MaxTags];
      reset_tags = '{8, 9, 35, 48, 22, 11, 41};
      sep_char = SepReset;
      for (int i = 0; i < MaxTags; i++) accepted_tags[i] = 16'(reset_tags[i]);
      errors = 0;
      bytes_taken = 0;
      results_checked = 0;
      fields_ok = 0;
      errors_flagged = 0;
      reg_writes = 0;
      restart();
    endfunction

    function void restart();
      state = PARSE_TAG;
      tag_acc = '0;
      have_digit = 1'b0;
      position = '0;
      value_start = '0;
    endfunction

    function void queue_result(result_t r);
      expected_fields.insert(expected_fields.size(), r);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
      reg_writes++;
      if (idx == CfgSeparator) begin
        sep_char = data[7:0];
      end else if (idx >= CfgTagFirst && idx < CfgTagFirst + MaxTags) begin
        accepted_tags[idx - CfgTagFirst] = data;
      end
    endfunction

    function logic [2:0] slot_of(logic [15:0] tag);
      for (int i = 0; i < MaxTags; i++) begin
        if (accepted_tags[i] != '0 && accepted_tags[i] == tag) return 3'(i + 1);
      end
      return 3'd0;
    endfunction

    function void flag_error(status_e st, bit is_last);
      result_t r;
      r.field_tag = '0;
      r.slot_index = '0;
      r.value_offset = position;
      r.value_length = '0;
      r.status = st;
      r.end_of_message = is_last;
      queue_result(r);
      errors_flagged++;
      if (is_last) restart();
      else state = PARSE_SKIP;
    endfunction

    // One accepted message byte; queues the result it causes, if any.
    function void note_byte(logic [7:0] b, bit is_last);
      int unsigned acc;
      result_t r;
      bytes_taken++;
      if (state == PARSE_SKIP) begin
        if (is_last) restart();
        return;
      end
      if (position == MaxPosition) begin
        flag_error(ST_TOOLONG, is_last);
        return;
      end
      if (state == PARSE_TAG) begin
        if (b == CharEqual) begin
          if (!have_digit) begin
            flag_error(ST_BADTAG, is_last);
            return;
          end
          if (is_last) begin
            flag_error(ST_UNTERM, is_last);
            return;
          end
          state = PARSE_VALUE;
          value_start = position + 16'd1;
        end else if (b >= CharZero && b <= CharNine) begin
          acc = 32'(tag_acc) * 32'd10 + 32'(b - CharZero);
          if (acc > 32'hFFFF) begin
            flag_error(ST_BADTAG, is_last);
            return;
          end
          if (is_last) begin
            flag_error(ST_UNTERM, is_last);
            return;
          end
          tag_acc = acc[15:0];
          have_digit = 1'b1;
        end else begin
          flag_error(ST_BADTAG, is_last);
          return;
        end
        position++;
        return;
      end
      // value: separator test comes first
      if (b == sep_char) begin
        if (position == value_start) begin
          flag_error(ST_EMPTY, is_last);
          return;
        end
        r.field_tag = tag_acc;
        r.slot_index = slot_of(tag_acc);
        r.value_offset = value_start;
        r.value_length = position - value_start;
        r.status = ST_OK;
        r.end_of_message = is_last;
        queue_result(r);
        fields_ok++;
        if (is_last) begin
          restart();
        end else begin
          state = PARSE_TAG;
          tag_acc = '0;
          have_digit = 1'b0;
          position++;
        end
        return;
      end
      if (is_last) begin
        flag_error(ST_UNTERM, is_last);
        return;
      end
      position++;
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_fields.size() == 0) begin
        report($sformatf("result with nothing expected: tag %0d status %0d offset %0d",
                         got.field_tag, got.status, got.value_offset));
        return;
      end
      want = expected_fields.pop_front();
      results_checked++;
      if (got.field_tag !== want.field_tag)
        report($sformatf("result %0d: field_tag %0d, expected %0d",
                         results_checked, got.field_tag, want.field_tag));
      if (got.slot_index !== want.slot_index)
        report($sformatf("result %0d: slot_index %0d, expected %0d",
                         results_checked, got.slot_index, want.slot_index));
      if (got.value_offset !== want.value_offset)
        report($sformatf("result %0d: value_offset %0d, expected %0d",
                         results_checked, got.value_offset, want.value_offset));
      if (got.value_length !== want.value_length)
        report($sformatf("result %0d: value_length %0d, expected %0d",
                         results_checked, got.value_length, want.value_length));
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         results_checked, got.status, want.status));
      if (got.end_of_message !== want.end_of_message)
        report($sformatf("result %0d: end_of_message %0d, expected %0d",
                         results_checked, got.end_of_message, want.end_of_message));
    endtask

    function int unsigned pending();
      return expected_fields.size();
    endfunction

    task flush_leftovers();
      result_t want;
      while (expected_fields.size() != 0) begin
        want = expected_fields.pop_front();
        report($sformatf("missing result: tag %0d status %0d offset %0d",
                         want.field_tag, want.status, want.value_offset));
      end
    endtask
  endclass

endpackage

// ===== tb/tag_value_field_parser_tb.sv =====
// Top-level testbench for the tag/value field parser.
`timescale 1ns / 1ps
module tag_value_field_parser_tb;
  import tvp_pkg::*;
  import tvp_tb_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainLimit    = 5000;
  localparam int unsigned BytesPerPhase = 275;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned HoldCycles    = 120;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        field_tag_o;
  logic [2:0]         slot_index_o;
  logic [15:0]        value_offset_o;
  logic [15:0]        value_length_o;
  logic [2:0]         status_o;
  logic               end_of_message_o;

  field_scoreboard sb;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     hold_req = 0;
  int unsigned     hold_left = 0;
  int unsigned     cycle_count = 0;
  int unsigned     rand_bytes = 0;
  logic [7:0]      msg_bytes [$];

  tag_value_field_parser #(
    .NUM_TAGS(MaxTags)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .field_tag_o     (field_tag_o),
    .slot_index_o    (slot_index_o),
    .value_offset_o  (value_offset_o),
    .value_length_o  (value_length_o),
    .status_o        (status_o),
    .end_of_message_o(end_of_message_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.field_tag = field_tag_o;
      seen.slot_index = slot_index_o;
      seen.value_offset = value_offset_o;
      seen.value_length = value_length_o;
      seen.status = status_e'(status_o);
      seen.end_of_message = end_of_message_o;
      sb.check_result(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b, is_last);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit is_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], is_last && i == s.len() - 1);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    rand_bytes += msg_bytes.size();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(input int unsigned ph);
    logic [7:0]  sep;
    int unsigned tags [MaxTags];
    case (ph)
      1: begin
        sep = 8'h00;
        tags = '{0, 65535, 65535, 0, 8, 1, 0};
      end
      2: begin
        sep = 8'hFF;
        foreach (tags[i]) tags[i] = $urandom_range(65535);
      end
      3: begin
        sep = CharEqual;
        foreach (tags[i]) tags[i] = $urandom_range(200);
      end
      4: begin
        sep = 8'h01;
        foreach (tags[i]) tags[i] = $urandom_range(65535);
      end
      default: begin
        sep = CharZero;
        foreach (tags[i]) tags[i] = $urandom_range(999);
      end
    endcase
    write_reg(CfgSeparator, {8'($urandom_range(255)), sep});
    for (int i = 0; i < MaxTags; i++) write_reg(CfgIdxW'(CfgTagFirst + i), 16'(tags[i]));
    // indexes past the last tag register must be ignored
    if (ph == 4) begin
      for (int k = 0; k < 2; k++)
        write_reg(CfgIdxW'(CfgTagFirst + MaxTags + $urandom_range(MaxTags)), 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    sb.flush_leftovers();
  endtask

  function automatic void append_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function automatic void add_field(input logic [7:0] sep);
    int unsigned pick;
    int unsigned tag_val;
    int unsigned vlen;
    string       digits;
    logic [7:0]  v;
    pick = $urandom_range(99);
    if (pick < 50) tag_val = sb.accepted_tags[$urandom_range(MaxTags - 1)];
    else if (pick < 70) tag_val = $urandom_range(99);
    else if (pick < 92) tag_val = $urandom_range(65535);
    else tag_val = $urandom_range(99999, 65536);
    if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) append_byte(CharZero);
    digits = $sformatf("%0d", tag_val);
    for (int i = 0; i < digits.len(); i++) append_byte(digits[i]);
    append_byte(CharEqual);
    vlen = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
    repeat (vlen) begin
      do v = 8'($urandom_range(255)); while (v == sep);
      append_byte(v);
    end
    append_byte(sep);
  endfunction

  // mostly well-formed messages; some cut short, some plain noise
  function automatic void build_message(input logic [7:0] sep);
    int unsigned kind;
    int unsigned keep;
    msg_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 88) begin
      repeat ($urandom_range(4, 1)) add_field(sep);
      if (kind >= 74) begin
        keep = $urandom_range(msg_bytes.size() - 1, 1);
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end
    end else begin
      repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    int unsigned phase_bytes;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 34;
    rx_idle_pct = 63;
    send_text("8=A;", 1'b1);
    send_text("0=;", 1'b0);        // empty value, then skip to the last byte
    send_byte("z", 1'b1);
    send_byte(CharEqual, 1'b1);    // '=' with no tag digit
    send_text("65536", 1'b0);      // tag overflow
    send_byte("x", 1'b1);
    send_text("41", 1'b1);         // unterminated in the tag
    send_text("9=", 1'b0);
    send_byte(8'hFF, 1'b1);        // unterminated in the value
    send_text("041==;", 1'b1);     // leading zero, '=' inside the value
    send_byte(8'h00, 1'b1);        // non-digit in the tag
    drain_results();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      phase_bytes = 0;
      if (ph != 0) configure(ph);
      if (ph == 4) hold_req = HoldCycles;
      while (phase_bytes < BytesPerPhase) begin
        if (rand_bytes < 2 * BytesPerPhase) begin
          tx_idle_pct = 34;
          rx_idle_pct = 63;
        end else if (rand_bytes < 4 * BytesPerPhase) begin
          tx_idle_pct = 63;
          rx_idle_pct = 34;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        build_message(sb.sep_char);
        send_message();
        phase_bytes += msg_bytes.size();
      end
      drain_results();
    end

    $display("Parsed %0d message bytes across %0d register settings;",
             sb.bytes_taken, RandomPhases);
    $display("checked %0d results (%0d fields, %0d errors) after %0d register writes.",
             sb.results_checked, sb.fields_ok, sb.errors_flagged, sb.reg_writes);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tvp_pkg.sv
rtl/tvp_slot_match.sv
rtl/tvp_out_buf.sv
rtl/tag_value_field_parser.sv
tb/tvp_tb_pkg.sv
tb/tag_value_field_parser_tb.sv
